// ===== rtl/core/elgc_pkg.sv =====
// elgc_pkg: shared types, constants and helpers for the byte cipher core
// no dependencies; used by the channel interfaces, the multiplier and the top level
`timescale 1ns / 1ps

package elgc_pkg;

  localparam int MOD_W     = 16;
  localparam int BYTE_W    = 8;
  localparam int PAD_W     = MOD_W - BYTE_W;
  localparam int CFG_IDX_W = 2;
  localparam int CNT_W     = $clog2(MOD_W);

  localparam logic [MOD_W-1:0] MODULUS_RST = MOD_W'(257);
  localparam logic [MOD_W-1:0] GEN_RST     = MOD_W'(3);
  localparam logic [MOD_W-1:0] PRIV_RST    = MOD_W'(123);
  localparam logic [MOD_W-1:0] SPUB_RST    = '0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODULUS = 2'd0,
    CFG_GENERATOR = 2'd1,
    CFG_PRIVATE = 2'd2,
    CFG_STORED_PUB = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    STAT_OK = 2'd0,
    STAT_ZERO = 2'd1,
    STAT_RANGE = 2'd2,
    STAT_KEY = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PRED,
    ST_PRED_W,
    ST_PBIT,
    ST_PMUL_W,
    ST_PSQ,
    ST_PSQ_W,
    ST_MUL_W,
    ST_NEXT,
    ST_OUT
  } state_t;

  typedef enum logic [2:0] {
    PH_Y,
    PH_A,
    PH_T,
    PH_B,
    PH_XR,
    PH_INV,
    PH_PLAIN
  } phase_t;

  typedef struct packed {
    logic             start;
    logic [MOD_W-1:0] x;
    logic [MOD_W-1:0] y;
    logic [MOD_W-1:0] m;
  } mul_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [MOD_W-1:0] result;
  } mul_rsp_t;

  // 1 mod m, with m of 0 or 1 giving 0
  function automatic logic [MOD_W-1:0] one_mod(input logic [MOD_W-1:0] m);
    logic [MOD_W-1:0] r;
    r = (m > MOD_W'(1)) ? MOD_W'(1) : '0;
    return r;
  endfunction

endpackage

// ===== rtl/core/elgc_in_if.sv =====
// elgc_in_if: input channel, valid/ready plus one item
// depends on elgc_pkg
`timescale 1ns / 1ps

interface elgc_in_if;
  import elgc_pkg::*;

  logic              valid;
  logic              ready;
  logic              mode;
  logic [BYTE_W-1:0] msg_byte;
  logic [MOD_W-1:0]  ephemeral_exp;
  logic [MOD_W-1:0]  pair_first;
  logic [MOD_W-1:0]  pair_second;

  modport source (
    output valid, mode, msg_byte, ephemeral_exp, pair_first, pair_second,
    input  ready
  );
  modport sink (
    input  valid, mode, msg_byte, ephemeral_exp, pair_first, pair_second,
    output ready
  );
endinterface

// ===== rtl/core/elgc_out_if.sv =====
// elgc_out_if: result channel, valid/ready plus one result
// depends on elgc_pkg
`timescale 1ns / 1ps

interface elgc_out_if;
  import elgc_pkg::*;

  logic              valid;
  logic              ready;
  logic [MOD_W-1:0]  out_first;
  logic [MOD_W-1:0]  out_second;
  logic [BYTE_W-1:0] plain_byte;
  logic [MOD_W-1:0]  public_key;
  logic [1:0]        status;

  modport source (
    output valid, out_first, out_second, plain_byte, public_key, status,
    input  ready
  );
  modport sink (
    input  valid, out_first, out_second, plain_byte, public_key, status,
    output ready
  );
endinterface

// ===== rtl/core/elgc_cfg_if.sv =====
// elgc_cfg_if: register write channel, valid/ready plus index and data
// depends on elgc_pkg
`timescale 1ns / 1ps

interface elgc_cfg_if;
  import elgc_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [MOD_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/elgc_modmul.sv =====
// elgc_modmul: bit-serial interleaved modular multiplier, x * y mod m
// one bit of x per cycle, msb first; y must already be below m; depends on elgc_pkg
`timescale 1ns / 1ps

module elgc_modmul (
  input  logic              clk,
  input  logic              rst_n,
  input  elgc_pkg::mul_req_t req,
  output elgc_pkg::mul_rsp_t rsp
);
  import elgc_pkg::*;

  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MOD_W - 1);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [MOD_W-1:0] x_r;
  logic [MOD_W-1:0] y_r;
  logic [MOD_W-1:0] m_r;
  logic [MOD_W-1:0] acc_r;
  logic             zero_r;

  logic [MOD_W-1:0] addend;
  logic [MOD_W+1:0] t_sum;
  logic [MOD_W+1:0] m1;
  logic [MOD_W+1:0] m2;
  logic [MOD_W+1:0] t_red;

  always_comb begin
    addend = x_r[MOD_W-1] ? y_r : '0;
    t_sum  = {1'b0, acc_r, 1'b0} + {2'b00, addend};
    m1     = {2'b00, m_r};
    m2     = {1'b0, m_r, 1'b0};
    priority if (t_sum >= m2) begin
      t_red = t_sum - m2;
    end else if (t_sum >= m1) begin
      t_red = t_sum - m1;
    end else begin
      t_red = t_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start && !busy_r) begin
      x_r    <= req.x;
      y_r    <= req.y;
      m_r    <= req.m;
      zero_r <= (req.m == '0);
      acc_r  <= '0;
    end else if (busy_r) begin
      x_r   <= {x_r[MOD_W-2:0], 1'b0};
      acc_r <= t_red[MOD_W-1:0];
    end
  end

  assign rsp.busy   = busy_r;
  assign rsp.done   = done_r;
  assign rsp.result = zero_r ? '0 : acc_r;

endmodule

// ===== rtl/core/elgamal_byte_cipher_top.sv =====
// elgamal_byte_cipher_top: byte encrypt / pair decrypt over a small prime group
// each modular product is a full pass of the bit-serial multiplier, plus issue and handoff
// an exponent costs 1 + up to 31 products
// encrypt: three exponents and one product; decrypt: two exponents and two products
// one transaction at a time; the next is taken while a finished result waits in the output register
// reset: synchronous active-low, clears control and loads register defaults 257, 3, 123, 0
`timescale 1ns / 1ps

module elgamal_byte_cipher_top (
  input logic       clk,
  input logic       rst_n,
  elgc_cfg_if.sink  cfg_ch,
  elgc_in_if.sink   in_ch,
  elgc_out_if.source out_ch
);
  import elgc_pkg::*;

  logic [MOD_W-1:0] mod_r, gen_r, priv_r, spub_r;

  state_t state_r, state_nxt;
  phase_t phase_r, phase_nxt;

  logic              mode_r, mode_nxt;
  logic [BYTE_W-1:0] msg_r, msg_nxt;
  logic [MOD_W-1:0]  k_r, k_nxt;
  logic [MOD_W-1:0]  a_r, a_nxt;
  logic [MOD_W-1:0]  b_r, b_nxt;
  logic [MOD_W-1:0]  base_r, base_nxt;
  logic [MOD_W-1:0]  exp_r, exp_nxt;
  logic [MOD_W-1:0]  acc_r, acc_nxt;
  logic [MOD_W-1:0]  y_r, y_nxt;
  logic [MOD_W-1:0]  first_r, first_nxt;
  logic [MOD_W-1:0]  second_r, second_nxt;
  logic [BYTE_W-1:0] plain_r, plain_nxt;
  status_t           status_r, status_nxt;

  logic              out_valid_r;
  logic [MOD_W-1:0]  out_first_r, out_second_r, out_pub_r;
  logic [BYTE_W-1:0] out_plain_r;
  status_t           out_status_r;
  logic              out_load;

  logic [MOD_W-1:0] p_m1;
  logic [MOD_W-1:0] one_p;
  logic [MOD_W-1:0] one_q;
  logic             key_bad;
  logic             pair_bad;

  mul_req_t mul_req;
  mul_rsp_t mul_rsp;

  elgc_modmul u_modmul (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (mul_req),
    .rsp  (mul_rsp)
  );

  // configuration registers
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_r  <= MODULUS_RST;
      gen_r  <= GEN_RST;
      priv_r <= PRIV_RST;
      spub_r <= SPUB_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_idx_t'(cfg_ch.index))
        CFG_MODULUS:    mod_r  <= cfg_ch.data;
        CFG_GENERATOR:  gen_r  <= cfg_ch.data;
        CFG_PRIVATE:    priv_r <= cfg_ch.data;
        CFG_STORED_PUB: spub_r <= cfg_ch.data;
      endcase
    end
  end

  assign p_m1     = mod_r - MOD_W'(1);
  assign one_p    = one_mod(mod_r);
  assign one_q    = one_mod(p_m1);
  assign key_bad  = (spub_r == '0) || (spub_r >= mod_r) || (spub_r != acc_r);
  assign pair_bad = (a_r == '0) || (a_r >= mod_r) || (b_r >= mod_r);

  assign in_ch.ready = (state_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      phase_r <= PH_Y;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r   <= mode_nxt;
    msg_r    <= msg_nxt;
    k_r      <= k_nxt;
    a_r      <= a_nxt;
    b_r      <= b_nxt;
    base_r   <= base_nxt;
    exp_r    <= exp_nxt;
    acc_r    <= acc_nxt;
    y_r      <= y_nxt;
    first_r  <= first_nxt;
    second_r <= second_nxt;
    plain_r  <= plain_nxt;
    status_r <= status_nxt;
  end

  // sequencer: square-and-multiply on the shared multiplier, phases chain the exponents
  always_comb begin
    state_nxt  = state_r;
    phase_nxt  = phase_r;
    mode_nxt   = mode_r;
    msg_nxt    = msg_r;
    k_nxt      = k_r;
    a_nxt      = a_r;
    b_nxt      = b_r;
    base_nxt   = base_r;
    exp_nxt    = exp_r;
    acc_nxt    = acc_r;
    y_nxt      = y_r;
    first_nxt  = first_r;
    second_nxt = second_r;
    plain_nxt  = plain_r;
    status_nxt = status_r;
    out_load   = 1'b0;
    mul_req    = '{start: 1'b0, x: base_r, y: one_p, m: mod_r};

    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          mode_nxt   = in_ch.mode;
          msg_nxt    = in_ch.msg_byte;
          k_nxt      = in_ch.ephemeral_exp;
          a_nxt      = in_ch.pair_first;
          b_nxt      = in_ch.pair_second;
          first_nxt  = '0;
          second_nxt = '0;
          plain_nxt  = '0;
          base_nxt   = gen_r;
          exp_nxt    = priv_r;
          acc_nxt    = one_p;
          phase_nxt  = PH_Y;
          state_nxt  = ST_PRED;
        end
      end
      ST_PRED: begin
        mul_req   = '{start: 1'b1, x: base_r, y: one_p, m: mod_r};
        state_nxt = ST_PRED_W;
      end
      ST_PRED_W: begin
        if (mul_rsp.done) begin
          base_nxt  = mul_rsp.result;
          state_nxt = ST_PBIT;
        end
      end
      ST_PBIT: begin
        priority if (exp_r == '0) begin
          state_nxt = ST_NEXT;
        end else if (exp_r[0]) begin
          mul_req   = '{start: 1'b1, x: acc_r, y: base_r, m: mod_r};
          state_nxt = ST_PMUL_W;
        end else begin
          state_nxt = ST_PSQ;
        end
      end
      ST_PMUL_W: begin
        if (mul_rsp.done) begin
          acc_nxt   = mul_rsp.result;
          state_nxt = ST_PSQ;
        end
      end
      ST_PSQ: begin
        if (exp_r[MOD_W-1:1] == '0) begin
          exp_nxt   = '0;
          state_nxt = ST_PBIT;
        end else begin
          mul_req   = '{start: 1'b1, x: base_r, y: base_r, m: mod_r};
          state_nxt = ST_PSQ_W;
        end
      end
      ST_PSQ_W: begin
        if (mul_rsp.done) begin
          base_nxt  = mul_rsp.result;
          exp_nxt   = {1'b0, exp_r[MOD_W-1:1]};
          state_nxt = ST_PBIT;
        end
      end
      ST_MUL_W: begin
        if (mul_rsp.done) begin
          acc_nxt   = mul_rsp.result;
          state_nxt = ST_NEXT;
        end
      end
      ST_NEXT: begin
        unique case (phase_r)
          PH_Y: begin
            y_nxt = acc_r;
            priority if (!mode_r) begin
              base_nxt  = gen_r;
              exp_nxt   = k_r;
              acc_nxt   = one_p;
              phase_nxt = PH_A;
              state_nxt = ST_PRED;
            end else if (key_bad) begin
              status_nxt = STAT_KEY;
              state_nxt  = ST_OUT;
            end else if (pair_bad) begin
              status_nxt = STAT_RANGE;
              state_nxt  = ST_OUT;
            end else begin
              mul_req   = '{start: 1'b1, x: priv_r, y: one_q, m: p_m1};
              phase_nxt = PH_XR;
              state_nxt = ST_MUL_W;
            end
          end
          PH_A: begin
            first_nxt = acc_r;
            base_nxt  = y_r;
            exp_nxt   = k_r;
            acc_nxt   = one_p;
            phase_nxt = PH_T;
            state_nxt = ST_PRED;
          end
          PH_T: begin
            mul_req   = '{start: 1'b1, x: {{PAD_W{1'b0}}, msg_r}, y: acc_r, m: mod_r};
            phase_nxt = PH_B;
            state_nxt = ST_MUL_W;
          end
          PH_B: begin
            second_nxt = acc_r;
            status_nxt = ((y_r == '0) || (first_r == '0) || (acc_r == '0)) ?
                         STAT_ZERO : STAT_OK;
            state_nxt  = ST_OUT;
          end
          PH_XR: begin
            base_nxt  = a_r;
            exp_nxt   = p_m1 - acc_r;
            acc_nxt   = one_p;
            phase_nxt = PH_INV;
            state_nxt = ST_PRED;
          end
          PH_INV: begin
            mul_req   = '{start: 1'b1, x: b_r, y: acc_r, m: mod_r};
            phase_nxt = PH_PLAIN;
            state_nxt = ST_MUL_W;
          end
          PH_PLAIN: begin
            plain_nxt  = acc_r[BYTE_W-1:0];
            status_nxt = STAT_OK;
            state_nxt  = ST_OUT;
          end
          default: begin
            state_nxt = ST_IDLE;
          end
        endcase
      end
      ST_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_first_r  <= first_r;
      out_second_r <= second_r;
      out_plain_r  <= plain_r;
      out_pub_r    <= y_r;
      out_status_r <= status_r;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.out_first  = out_first_r;
  assign out_ch.out_second = out_second_r;
  assign out_ch.plain_byte = out_plain_r;
  assign out_ch.public_key = out_pub_r;
  assign out_ch.status     = out_status_r;

  // checks
  a_mul_idle_on_start: assert property (@(posedge clk) disable iff (!rst_n)
    mul_req.start |-> !mul_rsp.busy)
    else $error("multiplier started while busy");

  a_fail_no_plain: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && (out_ch.status != STAT_OK) |-> (out_ch.plain_byte == '0))
    else $error("plain byte nonzero on a flagged result");

  a_out_slot_filled: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT) && !out_valid_r |=> out_valid_r)
    else $error("finished result not moved to the output register");

  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    mul_rsp.done |-> (state_r == ST_PRED_W) || (state_r == ST_PMUL_W) ||
                     (state_r == ST_PSQ_W) || (state_r == ST_MUL_W))
    else $error("multiplier result arrived outside a wait state");

endmodule

// ===== verif/tb_top.sv =====
// tb_top: self-checking testbench for elgamal_byte_cipher_top, encrypt and decrypt traffic
// predicts each result from a local modular-power model and checks it against the output channel
// depends on elgc_pkg, elgc_in_if, elgc_out_if, elgc_cfg_if and the cipher top level
`timescale 1ns / 1ps

module tb_top;
  import elgc_pkg::*;

  localparam logic MODE_ENC = 1'b0;
  localparam logic MODE_DEC = 1'b1;
  localparam int   DRAIN_CYCLES = 2000;

  typedef logic [63:0] wide_t;

  typedef struct packed {
    logic [MOD_W-1:0]  first;
    logic [MOD_W-1:0]  second;
    logic [BYTE_W-1:0] plain;
    logic [MOD_W-1:0]  pub;
    status_t           status;
  } cipher_res_t;

  logic clk;
  logic rst_n;

  elgc_cfg_if cfg_ch ();
  elgc_in_if  in_ch ();
  elgc_out_if out_ch ();

  elgamal_byte_cipher_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // register shadow
  logic [MOD_W-1:0] key_mod  = MODULUS_RST;
  logic [MOD_W-1:0] key_gen  = GEN_RST;
  logic [MOD_W-1:0] key_priv = PRIV_RST;
  logic [MOD_W-1:0] key_spub = SPUB_RST;

  cipher_res_t pending_results[$];
  cipher_res_t last_res;
  int fail_count     = 0;
  int send_gap_pct   = 0;
  int sink_stall_pct = 0;
  int hold_left      = 0;
  int stall_left     = 0;
  bit no_idle        = 1'b0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #80_000_000;
    $display("Verification failed");
    $finish;
  end

  function automatic wide_t mul_mod(input wide_t x, input wide_t y, input wide_t p);
    if (p == 0) return '0;
    return ((x % p) * (y % p)) % p;
  endfunction

  function automatic wide_t pow_mod(input wide_t base, input wide_t ex, input wide_t p);
    wide_t acc;
    wide_t sq;
    wide_t e;
    if (p == 0) return '0;
    acc = 64'd1 % p;
    sq  = base % p;
    e   = ex;
    while (e != 0) begin
      if (e[0]) acc = mul_mod(acc, sq, p);
      sq = mul_mod(sq, sq, p);
      e  = e >> 1;
    end
    return acc;
  endfunction

  function automatic cipher_res_t predict_cipher(input logic mode, input logic [BYTE_W-1:0] msg,
                                                 input logic [MOD_W-1:0] eph,
                                                 input logic [MOD_W-1:0] pa,
                                                 input logic [MOD_W-1:0] pb);
    cipher_res_t r;
    wide_t p;
    wide_t g;
    wide_t x;
    wide_t spub;
    wide_t y;
    wide_t a_v;
    wide_t b_v;
    wide_t xr;
    wide_t inv;
    wide_t pl;
    r = '0;
    p    = wide_t'(key_mod);
    g    = wide_t'(key_gen);
    x    = wide_t'(key_priv);
    spub = wide_t'(key_spub);
    y = pow_mod(g, x, p);
    r.pub = y[MOD_W-1:0];
    r.status = STAT_OK;
    if (mode == MODE_ENC) begin
      a_v = pow_mod(g, wide_t'(eph), p);
      b_v = mul_mod(wide_t'(msg), pow_mod(y, wide_t'(eph), p), p);
      r.first  = a_v[MOD_W-1:0];
      r.second = b_v[MOD_W-1:0];
      if (y == 0 || a_v == 0 || b_v == 0) r.status = STAT_ZERO;
    end else begin
      if (spub == 0 || spub >= p || spub != y) begin
        r.status = STAT_KEY;
      end else if (wide_t'(pa) == 0 || wide_t'(pa) >= p || wide_t'(pb) >= p) begin
        r.status = STAT_RANGE;
      end else begin
        xr  = x % (p - 1);
        inv = pow_mod(wide_t'(pa), (p - 1) - xr, p);
        pl  = mul_mod(wide_t'(pb), inv, p);
        r.plain = pl[BYTE_W-1:0];
      end
    end
    return r;
  endfunction

  // result sink: random stalls plus a counted long hold-off
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst_n) begin
        out_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else if (!no_idle && $urandom_range(0, 99) < sink_stall_pct) begin
        out_ch.ready <= 1'b0;
        stall_left = $urandom_range(0, 8);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic check_field(input string name, input wide_t exp_v, input wide_t act_v);
    if (exp_v !== act_v) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
    end
  endtask

  // result checker
  initial begin
    cipher_res_t exp_r;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        if (pending_results.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result, expected none, actual first %0h second %0h status %0d",
                   $time, out_ch.out_first, out_ch.out_second, out_ch.status);
        end else begin
          exp_r = pending_results.pop_front();
          check_field("out_first", wide_t'(exp_r.first), wide_t'(out_ch.out_first));
          check_field("out_second", wide_t'(exp_r.second), wide_t'(out_ch.out_second));
          check_field("plain_byte", wide_t'(exp_r.plain), wide_t'(out_ch.plain_byte));
          check_field("public_key", wide_t'(exp_r.pub), wide_t'(out_ch.public_key));
          check_field("status", wide_t'(exp_r.status), wide_t'(out_ch.status));
        end
      end
    end
  end

  task automatic send_item(input logic mode, input logic [BYTE_W-1:0] msg,
                           input logic [MOD_W-1:0] eph, input logic [MOD_W-1:0] pa,
                           input logic [MOD_W-1:0] pb, output cipher_res_t res);
    if (!no_idle && $urandom_range(0, 99) < send_gap_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.mode          <= mode;
    in_ch.msg_byte      <= msg;
    in_ch.ephemeral_exp <= eph;
    in_ch.pair_first    <= pa;
    in_ch.pair_second   <= pb;
    do @(posedge clk); while (!in_ch.ready);
    res = predict_cipher(mode, msg, eph, pa, pb);
    pending_results.insert(pending_results.size(), res);
  endtask

  task automatic wait_drain();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [MOD_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      CFG_MODULUS:    key_mod  = value;
      CFG_GENERATOR:  key_gen  = value;
      CFG_PRIVATE:    key_priv = value;
      CFG_STORED_PUB: key_spub = value;
      default: ;
    endcase
  endtask

  task automatic load_key(input logic [MOD_W-1:0] p, input logic [MOD_W-1:0] g,
                          input logic [MOD_W-1:0] x, input logic [MOD_W-1:0] spub);
    wait_drain();
    write_reg(CFG_MODULUS, p);
    write_reg(CFG_GENERATOR, g);
    write_reg(CFG_PRIVATE, x);
    write_reg(CFG_STORED_PUB, spub);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic logic [MOD_W-1:0] public_of(input wide_t p, input wide_t g, input wide_t x);
    wide_t y;
    y = pow_mod(g, x, p);
    return y[MOD_W-1:0];
  endfunction

  task automatic run_mixed(input int n);
    int sent;
    int kind;
    logic [MOD_W-1:0] k;
    cipher_res_t r;
    sent = 0;
    while (sent < n) begin
      kind = $urandom_range(0, 9);
      if ($urandom_range(0, 7) == 0 || key_mod < 4)
        k = MOD_W'($urandom);
      else
        k = MOD_W'($urandom_range(2, key_mod - 2));
      if (kind < 6) begin
        // well-formed round trip
        send_item(MODE_ENC, BYTE_W'($urandom), k, MOD_W'($urandom), MOD_W'($urandom), r);
        send_item(MODE_DEC, BYTE_W'($urandom), MOD_W'($urandom), r.first, r.second, r);
        sent += 2;
      end else if (kind < 8) begin
        send_item(MODE_ENC, BYTE_W'($urandom), k, MOD_W'($urandom), MOD_W'($urandom), r);
        sent++;
      end else if (kind == 8) begin
        send_item(MODE_DEC, BYTE_W'($urandom), MOD_W'($urandom),
                  MOD_W'($urandom_range(0, key_mod)), MOD_W'($urandom_range(0, key_mod)), r);
        sent++;
      end else begin
        send_item(MODE_DEC, BYTE_W'($urandom), MOD_W'($urandom), MOD_W'($urandom),
                  MOD_W'($urandom), r);
        sent++;
      end
    end
  endtask

  // defaults after reset, stored key still zero
  task automatic test_reset_defaults();
    send_item(MODE_ENC, 8'h00, 16'd2, '0, '0, last_res);
    send_item(MODE_ENC, 8'hFF, 16'd0, '0, '0, last_res);
    send_item(MODE_ENC, 8'hAA, 16'hFFFF, '0, '0, last_res);
    send_item(MODE_DEC, 8'h00, 16'd0, 16'd5, 16'd7, last_res);
  endtask

  // pair range checks first, then a well-formed round trip, then the key check
  task automatic test_decrypt_checks();
    load_key(16'd257, 16'd3, 16'd123, public_of(64'd257, 64'd3, 64'd123));
    send_item(MODE_DEC, 8'h00, 16'd0, 16'd0, 16'd1, last_res);
    send_item(MODE_DEC, 8'h00, 16'd0, 16'd257, 16'd1, last_res);
    send_item(MODE_DEC, 8'h00, 16'd0, 16'd1, 16'd257, last_res);
    send_item(MODE_DEC, 8'h00, 16'd0, 16'd256, 16'd0, last_res);
    send_item(MODE_DEC, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, last_res);
    send_item(MODE_ENC, 8'h55, 16'd255, 16'hFFFF, 16'hFFFF, last_res);
    send_item(MODE_DEC, 8'h00, 16'd0, last_res.first, last_res.second, last_res);
    load_key(16'd65521, 16'd3, 16'd123, 16'hFFFF);
    send_item(MODE_DEC, 8'h00, 16'd0, 16'd5, 16'd5, last_res);
  endtask

  // private exponent past p-1, exponent zero, top and bottom of the register ranges
  task automatic test_exponent_edges();
    load_key(16'd65521, 16'd65534, 16'd65533, public_of(64'd65521, 64'd65534, 64'd65533));
    send_item(MODE_ENC, 8'hFF, 16'd65533, '0, '0, last_res);
    send_item(MODE_DEC, 8'h00, 16'd0, last_res.first, last_res.second, last_res);
    send_item(MODE_DEC, 8'h00, 16'd0, 16'd65520, 16'd65520, last_res);
    load_key(16'd257, 16'd3, 16'd0, 16'd1);
    send_item(MODE_ENC, 8'h07, 16'd3, '0, '0, last_res);
    send_item(MODE_DEC, 8'h00, 16'd0, last_res.first, last_res.second, last_res);
    load_key(16'd65535, 16'd2, 16'd2, public_of(64'd65535, 64'd2, 64'd2));
    send_item(MODE_ENC, 8'h81, 16'd1000, '0, '0, last_res);
    send_item(MODE_DEC, 8'h00, 16'd0, last_res.first, last_res.second, last_res);
    load_key(16'd5, 16'd2, 16'd2, public_of(64'd5, 64'd2, 64'd2));
    send_item(MODE_ENC, 8'd200, 16'd3, '0, '0, last_res);
    send_item(MODE_ENC, 8'd3, 16'd2, '0, '0, last_res);
    send_item(MODE_DEC, 8'h00, 16'd0, last_res.first, last_res.second, last_res);
  endtask

  // modulus of one and of zero
  task automatic test_degenerate_modulus();
    load_key(16'd1, 16'd3, 16'd5, 16'd0);
    send_item(MODE_ENC, 8'h12, 16'd9, '0, '0, last_res);
    send_item(MODE_DEC, 8'h00, 16'd0, 16'd0, 16'd0, last_res);
    load_key(16'd0, 16'd3, 16'd5, 16'd1);
    send_item(MODE_ENC, 8'h34, 16'd9, '0, '0, last_res);
    send_item(MODE_DEC, 8'h00, 16'd0, 16'd1, 16'd1, last_res);
  endtask

  task automatic test_random_traffic();
    logic [MOD_W-1:0] p;
    logic [MOD_W-1:0] g;
    logic [MOD_W-1:0] x;
    logic [MOD_W-1:0] spub;
    int sel;
    int pct_sel;
    for (int phase = 0; phase < 13; phase++) begin
      sel = $urandom_range(0, 9);
      case (sel)
        0: p = 16'd5;
        1: p = 16'd7;
        2: p = 16'd13;
        3: p = 16'd251;
        4: p = 16'd257;
        5: p = 16'd4093;
        6: p = 16'd65521;
        7: p = 16'd65535;
        default: p = MOD_W'($urandom_range(5, 65535));
      endcase
      if ($urandom_range(0, 7) == 0) g = MOD_W'($urandom);
      else g = MOD_W'($urandom_range(2, p - 2));
      if ($urandom_range(0, 7) == 0) x = MOD_W'($urandom);
      else x = MOD_W'($urandom_range(2, p - 3));
      spub = public_of(wide_t'(p), wide_t'(g), wide_t'(x));
      if ($urandom_range(0, 7) == 0) spub = MOD_W'($urandom);
      load_key(p, g, x, spub);
      pct_sel = $urandom_range(0, 2);
      send_gap_pct   = (pct_sel == 0) ? 0 : (pct_sel == 1) ? 10 : 35;
      pct_sel = $urandom_range(0, 2);
      sink_stall_pct = (pct_sel == 0) ? 0 : (pct_sel == 1) ? 10 : 35;
      run_mixed(60);
    end
  endtask

  // sink holds off long enough for the block to fill and stall its input
  task automatic test_output_backpressure();
    wait_drain();
    send_gap_pct = 0;
    hold_left    = 8000;
    run_mixed(8);
    wait_drain();
  endtask

  task automatic test_streaming();
    no_idle = 1'b1;
    run_mixed(90);
  endtask

  initial begin
    rst_n               <= 1'b0;
    in_ch.valid         <= 1'b0;
    in_ch.mode          <= MODE_ENC;
    in_ch.msg_byte      <= '0;
    in_ch.ephemeral_exp <= '0;
    in_ch.pair_first    <= '0;
    in_ch.pair_second   <= '0;
    cfg_ch.valid        <= 1'b0;
    cfg_ch.index        <= CFG_MODULUS;
    cfg_ch.data         <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_decrypt_checks();
    test_exponent_edges();
    test_degenerate_modulus();
    test_random_traffic();
    test_output_backpressure();
    test_streaming();
    wait_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
